>>> rtl/core/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold in the same cycle
`define CES_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// property that must hold in the next cycle
`define CES_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/ces_pkg.sv
// shared types, constants and gaussian weight table of the edge smoother
`timescale 1ns / 1ps
package ces_pkg;

    localparam int FIELD_W      = 16;
    localparam int IN_TDATA_W   = 48;
    localparam int OUT_TDATA_W  = 80;
    localparam int CFG_W        = 12;
    localparam int QUO_W        = 17;
    localparam logic [3:0]  RADIUS_RESET = 4'd3;
    localparam logic [11:0] TOL_RESET    = 12'd160;

    typedef enum logic {
        REG_WINDOW_RADIUS = 1'b0,
        REG_OUTLIER_TOL   = 1'b1
    } reg_idx_t;

    typedef logic [15:0] wtab_t [0:255];

    // restoring division, used only while the table is elaborated
    function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] q;
        logic [63:0] rm;
        q  = '0;
        rm = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rm = {rm[62:0], a[i]};
            if (rm >= b)
            begin
                rm   = rm - b;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // q15 weight exp(-o^2/(2 s^2)), taylor in q30 then four squarings
    function automatic logic [15:0] gauss_q15(input int r, input int o);
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] y;
        logic [63:0] t2;
        logic [63:0] t3;
        logic [63:0] t4;
        logic [63:0] v;
        if (r <= 1)
        begin
            num = 64'(o * o);
            den = 64'd2;
        end
        else
        begin
            num = 64'(50 * o * o);
            den = 64'(49 * r * r);
        end
        y  = udiv64(num << 30, den << 4);
        t2 = ((y * y) >> 30) / 64'd2;
        t3 = ((t2 * y) >> 30) / 64'd3;
        t4 = ((t3 * y) >> 30) / 64'd4;
        v  = (64'd1 << 30) - y + t2 - t3 + t4;
        for (int s = 0; s < 4; s++)
            v = (v * v) >> 30;
        return 16'((v + 64'd16384) >> 15);
    endfunction

    // indexed by {radius, offset}
    function automatic wtab_t gauss_build();
        wtab_t t;
        for (int rr = 0; rr < 16; rr++)
            for (int oo = 0; oo < 16; oo++)
                t[rr * 16 + oo] = (oo <= rr) ? gauss_q15(rr, oo) : 16'd0;
        return t;
    endfunction

    localparam wtab_t GAUSS_TAB = gauss_build();

endpackage

>>> rtl/core/ces_sorter.sv
// row of insertion cells that keeps the window sorted, one sample a cycle while insert is high
`timescale 1ns / 1ps
module ces_sorter
    import ces_pkg::*;
#(
    parameter int NCELL = 17
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              clear,
    input  logic                              insert,
    input  logic signed [FIELD_W-1:0]         din,
    input  logic [$clog2(NCELL)-1:0]          sel,
    output logic signed [FIELD_W-1:0]         median
);

    localparam int CW = $clog2(NCELL + 1);

    logic signed [FIELD_W-1:0] cells_reg [NCELL];
    logic signed [FIELD_W-1:0] cells_next [NCELL];
    logic [CW-1:0]             cnt_reg;
    logic [NCELL-1:0]          ge;

    always_comb
    begin
        for (int a = 0; a < NCELL; a++)
            ge[a] = (CW'(a) >= cnt_reg) || (cells_reg[a] > din);
        cells_next[0] = ge[0] ? din : cells_reg[0];
        for (int a = 1; a < NCELL; a++)
        begin
            if (!ge[a])
                cells_next[a] = cells_reg[a];
            else if (!ge[a-1])
                cells_next[a] = din;
            else
                cells_next[a] = cells_reg[a-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (insert)
            cells_reg <= cells_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (clear)
            cnt_reg <= '0;
        else if (insert)
            cnt_reg <= cnt_reg + 1'b1;
    end

    assign median = cells_reg[sel];

endmodule

>>> rtl/core/ces_divider.sv
// iterative divider for the weighted mean, rounds half away from zero
`timescale 1ns / 1ps
module ces_divider
    import ces_pkg::*;
#(
    parameter int SW = 37,
    parameter int TW = 20
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [SW-1:0]       num,
    input  logic [TW-1:0]              den,
    output logic                       done,
    output logic signed [FIELD_W-1:0]  quo
);

    localparam int CNTW = $clog2(QUO_W + 1);

    logic              run_reg;
    logic [CNTW-1:0]   cnt_reg;
    logic [TW-1:0]     rem_reg;
    logic [QUO_W-1:0]  low_reg;
    logic [QUO_W-1:0]  q_reg;
    logic [TW-1:0]     den_reg;
    logic              neg_reg;
    logic              done_reg;
    logic [SW-1:0]     mag;
    logic [TW:0]       trial;
    logic              qbit;
    logic signed [QUO_W-1:0] q_signed;

    always_comb
    begin
        mag   = (num[SW-1] ? SW'(-num) : SW'(num)) + SW'(den >> 1);
        trial = {rem_reg, low_reg[QUO_W-1]};
        qbit  = trial >= {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNTW'(QUO_W);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // quotient fits QUO_W bits, so the upper part starts below the divisor
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= mag[SW-1:QUO_W];
            low_reg <= mag[QUO_W-1:0];
            q_reg   <= '0;
            den_reg <= den;
            neg_reg <= num[SW-1];
        end
        else if (run_reg)
        begin
            rem_reg <= qbit ? TW'(trial - {1'b0, den_reg}) : trial[TW-1:0];
            low_reg <= {low_reg[QUO_W-2:0], 1'b0};
            q_reg   <= {q_reg[QUO_W-2:0], qbit};
        end
    end

    assign q_signed = neg_reg ? -$signed(q_reg) : $signed(q_reg);
    assign quo      = q_signed[FIELD_W-1:0];
    assign done     = done_reg;

endmodule

>>> rtl/core/contour_edge_smoother.sv
// top level: row buffers, sequencer and shared multiply-accumulate
// Smooths contour edges row by row. Rows arrive on the s_ channel, one
// transaction per row (left_x, right_x, row_y, tlast on the final row).
// Results leave on the m_ channel in row order with tlast on the final row.
// Each row is held 4R rows before its result comes out; the final row
// flushes all held rows as 4R+1 steps in one go.
// One sequencer walks every window sample through one sorting row and one
// multiplier; each gaussian mean is paced by the one-sample-a-cycle buffer
// read port and the 17-step divider. A row runs up to four means (two
// corrections, two outputs), and the final row runs up to four in each of
// its 4R+1 steps.
// s_tready is high only while the sequencer is idle. A finished result sits
// in an output register; when the receiver stalls the sequencer waits for it
// before loading the next one, and takes no new row while it waits.
// Reset clears the control state and restores radius 3 and tolerance 160;
// the row buffers need no clearing since no slot is read before written.
`timescale 1ns / 1ps
module contour_edge_smoother
    import ces_pkg::*;
#(
    parameter int MAX_RADIUS = 8,
    parameter int LINE_DEPTH = 64
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [IN_TDATA_W-1:0]   s_tdata,   // left_x, right_x, row_y
    input  logic                    s_tlast,   // last_row
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [OUT_TDATA_W-1:0]  m_tdata,   // smooth_left, smooth_right, center_x,
                                               // edge_width, out_row_y
    output logic                    m_tlast,   // end_of_track
    input  logic                    cfg_we,
    input  logic                    cfg_index,
    input  logic [CFG_W-1:0]        cfg_wdata
);

    localparam int RW    = $clog2(MAX_RADIUS + 1);
    localparam int DW    = $clog2(6 * MAX_RADIUS + 1) + 2;
    localparam int KW    = $clog2(4 * MAX_RADIUS + 1);
    localparam int AW    = $clog2(LINE_DEPTH);
    localparam int NCELL = 2 * MAX_RADIUS + 1;
    localparam int SELW  = $clog2(NCELL);
    localparam int TW    = $clog2(NCELL * 32768 + 1);
    localparam int SW    = TW + FIELD_W + 1;
    localparam int PW    = 2 * FIELD_W + 1;

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_KCORR  = 14'b00000000000010,
        S_KOUT   = 14'b00000000000100,
        S_KNEXT  = 14'b00000000001000,
        S_MINIT  = 14'b00000000010000,
        S_MFETCH = 14'b00000000100000,
        S_MDRAIN = 14'b00000001000000,
        S_MMUL   = 14'b00000010000000,
        S_MACC   = 14'b00000100000000,
        S_DIV    = 14'b00001000000000,
        S_RAWRD  = 14'b00010000000000,
        S_CORRWR = 14'b00100000000000,
        S_ROWRD  = 14'b01000000000000,
        S_EMIT   = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [3:0]               radius_cfg_reg;
    logic [11:0]              tol_reg;
    logic [RW-1:0]            r_reg, r_next;
    logic [15:0]              rows_seen_reg, rows_seen_next;
    logic [15:0]              n_reg, n_next;
    logic [AW-1:0]            head_reg, head_next;
    logic                     last_reg, last_next;
    logic [KW-1:0]            k_reg, k_next;
    logic                     phase_reg, phase_next;
    logic                     side_reg, side_next;
    logic signed [DW-1:0]     center_reg, center_next;
    logic signed [DW-1:0]     o_reg, o_next;
    logic signed [DW-1:0]     q_reg, q_next;
    logic signed [DW-1:0]     ctr_reg, ctr_next;
    logic                     rvalid_reg;
    logic signed [PW-1:0]     prod_reg;
    logic signed [SW-1:0]     acc_reg, acc_next;
    logic [TW-1:0]            tot_reg, tot_next;
    logic signed [FIELD_W-1:0] base_reg, base_next;
    logic signed [FIELD_W-1:0] left_res_reg, left_res_next;
    logic signed [FIELD_W-1:0] right_res_reg, right_res_next;

    logic                     out_valid_reg, out_valid_next;
    logic                     out_last_reg;
    logic [OUT_TDATA_W-1:0]   out_data_reg;

    logic signed [FIELD_W-1:0] raw_l_mem [LINE_DEPTH];
    logic signed [FIELD_W-1:0] raw_r_mem [LINE_DEPTH];
    logic signed [FIELD_W-1:0] corr_l_mem [LINE_DEPTH];
    logic signed [FIELD_W-1:0] corr_r_mem [LINE_DEPTH];
    logic [FIELD_W-1:0]        row_mem [LINE_DEPTH];
    logic signed [FIELD_W-1:0] raw_l_q, raw_r_q, corr_l_q, corr_r_q;
    logic [FIELD_W-1:0]        row_q;

    logic                     accept;
    logic [AW-1:0]            head_inc;
    logic signed [DW-1:0]     r_s, k_s, dj, di, o_abs;
    logic [KW-1:0]            kmax;
    logic [DW-1:0]            addr_d;
    logic [AW-1:0]            rd_addr;
    logic signed [FIELD_W-1:0] line_q;
    logic signed [FIELD_W-1:0] median;
    logic [15:0]              w_cur;
    logic signed [SW-1:0]     acc_sum;
    logic [TW-1:0]            tot_sum;
    logic                     div_start, div_done;
    logic signed [FIELD_W-1:0] div_q;
    logic signed [FIELD_W:0]  diff, adiff;
    logic signed [FIELD_W-1:0] corr_val;
    logic                     corr_we;
    logic                     load_out;
    logic signed [FIELD_W:0]  lr_sum, lr_diff;
    logic [FIELD_W-1:0]       width_val;

    function automatic logic in_range(input logic signed [DW-1:0] x, input logic [15:0] n);
        return !x[DW-1] && (16'(unsigned'(x)) <= n);
    endfunction

    // clamp a distance from the newest row into [0, n]
    function automatic logic [DW-1:0] clampd(input logic signed [DW-1:0] x,
                                             input logic [15:0] n);
        logic [DW-1:0] res;
        if (x[DW-1])
            res = '0;
        else if (16'(unsigned'(x)) > n)
            res = n[DW-1:0];
        else
            res = unsigned'(x);
        return res;
    endfunction

    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                              input logic [DW-1:0] d);
        logic [AW:0] h;
        logic [AW:0] de;
        logic [AW:0] s;
        h  = {1'b0, head};
        de = (AW+1)'(d);
        if (h >= de)
            s = h - de;
        else
            s = h + (AW+1)'(LINE_DEPTH) - de;
        return s[AW-1:0];
    endfunction

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign head_inc = (head_reg == AW'(LINE_DEPTH - 1)) ? '0 : head_reg + 1'b1;

    assign r_s   = signed'(DW'(r_reg));
    assign k_s   = signed'(DW'(k_reg));
    assign dj    = (r_s <<< 1) - k_s;
    assign di    = (r_s <<< 2) - k_s;
    assign kmax  = last_reg ? KW'({r_reg, 2'b00}) : '0;
    assign o_abs = o_reg[DW-1] ? -o_reg : o_reg;
    assign w_cur = GAUSS_TAB[{4'(r_reg), 4'(o_abs)}];

    assign addr_d  = (state_reg == S_MFETCH) ? clampd(ctr_reg - q_reg, n_reg)
                                             : unsigned'(center_reg);
    assign rd_addr = slot_of(head_reg, addr_d);

    assign line_q = phase_reg ? (side_reg ? corr_r_q : corr_l_q)
                              : (side_reg ? raw_r_q : raw_l_q);

    assign acc_sum   = acc_reg + SW'(prod_reg);
    assign tot_sum   = tot_reg + TW'(w_cur);
    assign div_start = (state_reg == S_MACC) && (o_reg == r_s);

    // outlier test against the baseline
    assign diff     = signed'({line_q[FIELD_W-1], line_q})
                    - signed'({base_reg[FIELD_W-1], base_reg});
    assign adiff    = diff[FIELD_W] ? -diff : diff;
    assign corr_val = (adiff > signed'((FIELD_W+1)'(tol_reg))) ? base_reg : line_q;
    assign corr_we  = (state_reg == S_CORRWR);

    assign load_out  = (state_reg == S_EMIT) && (!out_valid_reg || m_tready);
    assign lr_sum    = signed'({left_res_reg[FIELD_W-1], left_res_reg})
                     + signed'({right_res_reg[FIELD_W-1], right_res_reg});
    assign lr_diff   = signed'({right_res_reg[FIELD_W-1], right_res_reg})
                     - signed'({left_res_reg[FIELD_W-1], left_res_reg});
    assign width_val = lr_diff[FIELD_W] ? '0 : lr_diff[FIELD_W-1:0];

    ces_sorter #(
        .NCELL (NCELL)
    ) u_sorter (
        .clk    (clk),
        .rst_n  (rst_n),
        .clear  (state_reg == S_MINIT),
        .insert (rvalid_reg),
        .din    (line_q),
        .sel    (SELW'(r_reg)),
        .median (median)
    );

    ces_divider #(
        .SW (SW),
        .TW (TW)
    ) u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (acc_sum),
        .den   (tot_sum),
        .done  (div_done),
        .quo   (div_q)
    );

    always_comb
    begin
        state_next     = state_reg;
        r_next         = r_reg;
        rows_seen_next = rows_seen_reg;
        n_next         = n_reg;
        head_next      = head_reg;
        last_next      = last_reg;
        k_next         = k_reg;
        phase_next     = phase_reg;
        side_next      = side_reg;
        center_next    = center_reg;
        o_next         = o_reg;
        q_next         = q_reg;
        ctr_next       = ctr_reg;
        acc_next       = acc_reg;
        tot_next       = tot_reg;
        base_next      = base_reg;
        left_res_next  = left_res_reg;
        right_res_next = right_res_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (load_out)
            out_valid_next = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (rows_seen_reg == '0)
                        r_next = (radius_cfg_reg > 4'(MAX_RADIUS)) ? RW'(MAX_RADIUS)
                                                                   : RW'(radius_cfg_reg);
                    n_next         = rows_seen_reg;
                    rows_seen_next = (rows_seen_reg == 16'hFFFF) ? rows_seen_reg
                                                                 : rows_seen_reg + 1'b1;
                    head_next      = head_inc;
                    last_next      = s_tlast;
                    k_next         = '0;
                    state_next     = S_KCORR;
                end
            end
            S_KCORR:
            begin
                if (in_range(dj, n_reg))
                begin
                    phase_next  = 1'b0;
                    side_next   = 1'b0;
                    center_next = dj;
                    o_next      = -r_s;
                    acc_next    = '0;
                    tot_next    = '0;
                    state_next  = S_MINIT;
                end
                else
                    state_next = S_KOUT;
            end
            S_KOUT:
            begin
                if (in_range(di, n_reg))
                begin
                    phase_next  = 1'b1;
                    side_next   = 1'b0;
                    center_next = di;
                    o_next      = -r_s;
                    acc_next    = '0;
                    tot_next    = '0;
                    state_next  = S_MINIT;
                end
                else
                    state_next = S_KNEXT;
            end
            S_KNEXT:
            begin
                if (k_reg == kmax)
                begin
                    if (last_reg)
                        rows_seen_next = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_KCORR;
                end
            end
            S_MINIT:
            begin
                ctr_next   = signed'(clampd(center_reg - o_reg, n_reg));
                q_next     = -r_s;
                state_next = S_MFETCH;
            end
            S_MFETCH:
            begin
                q_next = q_reg + 1'b1;
                if (q_reg == r_s)
                    state_next = S_MDRAIN;
            end
            S_MDRAIN:
                state_next = S_MMUL;
            S_MMUL:
                state_next = S_MACC;
            S_MACC:
            begin
                acc_next = acc_sum;
                tot_next = tot_sum;
                if (o_reg == r_s)
                    state_next = S_DIV;
                else
                begin
                    o_next     = o_reg + 1'b1;
                    state_next = S_MINIT;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (!phase_reg)
                    begin
                        base_next  = div_q;
                        state_next = S_RAWRD;
                    end
                    else if (!side_reg)
                    begin
                        left_res_next = div_q;
                        side_next     = 1'b1;
                        o_next        = -r_s;
                        acc_next      = '0;
                        tot_next      = '0;
                        state_next    = S_MINIT;
                    end
                    else
                    begin
                        right_res_next = div_q;
                        state_next     = S_ROWRD;
                    end
                end
            end
            S_RAWRD:
                state_next = S_CORRWR;
            S_CORRWR:
            begin
                if (!side_reg)
                begin
                    side_next  = 1'b1;
                    o_next     = -r_s;
                    acc_next   = '0;
                    tot_next   = '0;
                    state_next = S_MINIT;
                end
                else
                    state_next = S_KOUT;
            end
            S_ROWRD:
                state_next = S_EMIT;
            S_EMIT:
            begin
                if (load_out)
                    state_next = S_KNEXT;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            radius_cfg_reg <= RADIUS_RESET;
            tol_reg        <= TOL_RESET;
            r_reg          <= RW'(RADIUS_RESET);
            rows_seen_reg  <= '0;
            n_reg          <= '0;
            head_reg       <= '0;
            last_reg       <= 1'b0;
            k_reg          <= '0;
            phase_reg      <= 1'b0;
            side_reg       <= 1'b0;
            o_reg          <= '0;
            q_reg          <= '0;
            rvalid_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            r_reg         <= r_next;
            rows_seen_reg <= rows_seen_next;
            n_reg         <= n_next;
            head_reg      <= head_next;
            last_reg      <= last_next;
            k_reg         <= k_next;
            phase_reg     <= phase_next;
            side_reg      <= side_next;
            o_reg         <= o_next;
            q_reg         <= q_next;
            rvalid_reg    <= (state_reg == S_MFETCH);
            out_valid_reg <= out_valid_next;
            if (cfg_we && cfg_index == REG_WINDOW_RADIUS)
                radius_cfg_reg <= cfg_wdata[3:0];
            if (cfg_we && cfg_index == REG_OUTLIER_TOL)
                tol_reg <= cfg_wdata[11:0];
        end
    end

    always_ff @(posedge clk)
    begin
        center_reg    <= center_next;
        ctr_reg       <= ctr_next;
        acc_reg       <= acc_next;
        tot_reg       <= tot_next;
        base_reg      <= base_next;
        left_res_reg  <= left_res_next;
        right_res_reg <= right_res_next;
        prod_reg      <= median * signed'({1'b0, w_cur});
        if (load_out)
        begin
            out_data_reg <= {row_q, width_val, lr_sum[FIELD_W:1],
                             right_res_reg, left_res_reg};
            out_last_reg <= last_reg && (di == '0);
        end
    end

    // row buffers: one write port each, read data registered
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            raw_l_mem[head_inc] <= s_tdata[15:0];
            raw_r_mem[head_inc] <= s_tdata[31:16];
            row_mem[head_inc]   <= s_tdata[47:32];
        end
        if (corr_we && !side_reg)
            corr_l_mem[rd_addr] <= corr_val;
        if (corr_we && side_reg)
            corr_r_mem[rd_addr] <= corr_val;
        raw_l_q  <= raw_l_mem[rd_addr];
        raw_r_q  <= raw_r_mem[rd_addr];
        corr_l_q <= corr_l_mem[rd_addr];
        corr_r_q <= corr_r_mem[rd_addr];
        row_q    <= row_mem[rd_addr];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

>>> rtl/core/ces_checker.sv
// port-level checker for the edge smoother, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ces_checker
    import ces_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    input  logic                    s_tready,
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic [OUT_TDATA_W-1:0]  m_tdata,
    input  logic                    m_tlast
);

    logic signed [FIELD_W:0] lr_sum;
    logic signed [FIELD_W:0] lr_diff;

    assign lr_sum  = signed'({m_tdata[15], m_tdata[15:0]})
                   + signed'({m_tdata[31], m_tdata[31:16]});
    assign lr_diff = signed'({m_tdata[31], m_tdata[31:16]})
                   - signed'({m_tdata[15], m_tdata[15:0]});

    // a row keeps the sequencer busy, so ready is low in the cycle after it
    `CES_ASSERT_NEXT(a_busy_after_row, clk, rst_n, s_tvalid && s_tready, !s_tready, "ready high right after a row transaction")

    `CES_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

    `CES_ASSERT_NOW(a_center, clk, rst_n, m_tvalid, m_tdata[47:32] == lr_sum[FIELD_W:1], "center is not the floor midpoint of the edges")

    `CES_ASSERT_NOW(a_width, clk, rst_n, m_tvalid, lr_diff[FIELD_W] ? (m_tdata[63:48] == '0) : (m_tdata[63:48] == lr_diff[FIELD_W-1:0]), "width does not match the edges")

endmodule

bind contour_edge_smoother ces_checker u_ces_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

>>> verif/testbench.sv
// self-checking testbench for the contour edge smoother
`timescale 1ns / 1ps
module testbench;
    import ces_pkg::*;

    localparam int DEPTH      = 64;
    localparam int RADIUS_CAP = 8;
    localparam int IDLE_LIMIT = 200000;

    typedef struct {
        logic signed [15:0] left_e;
        logic signed [15:0] right_e;
        logic signed [15:0] centre;
        logic [15:0]        span;
        logic [15:0]        row;
        logic               eot;
    } edge_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   cfg_we;
    reg_idx_t               cfg_index;
    logic [CFG_W-1:0]       cfg_wdata;

    contour_edge_smoother dut (.*);

    // shadow of the row buffers: raw left, raw right, corrected left, corrected right
    int edge_mem [4][DEPTH];
    int row_mem [DEPTH];
    int rows_in_track;
    int ring_head;
    int track_radius;
    int radius_reg;
    int tol_reg;

    edge_result_t smoothed_q[$];
    int  mismatches;
    int  idle_cycles;
    bit  no_idling;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // weight in q15, taylor series in q30 then four squarings
    function automatic longint unsigned weight_q15(int r, int o);
        longint unsigned num, den, y, t2, t3, t4, v;
        if (r <= 1)
        begin
            num = o * o;
            den = 2;
        end
        else
        begin
            num = 50 * o * o;
            den = 49 * r * r;
        end
        y  = (num << 30) / (den * 16);
        t2 = ((y * y) >> 30) / 2;
        t3 = ((t2 * y) >> 30) / 3;
        t4 = ((t3 * y) >> 30) / 4;
        v  = (64'd1 << 30) - y + t2 - t3 + t4;
        for (int s = 0; s < 4; s++)
            v = (v * v) >> 30;
        return (v + 64'd16384) >> 15;
    endfunction

    function automatic int slot(int a, int n);
        return (ring_head + DEPTH - ((n - a) % DEPTH)) % DEPTH;
    endfunction

    function automatic int sample_at(int sel, int a, int n);
        if (a < 0)
            a = 0;
        if (a > n)
            a = n;
        return edge_mem[sel][slot(a, n)];
    endfunction

    function automatic int window_median(int sel, int k, int n, int r);
        int w [2*RADIUS_CAP+1];
        int cnt;
        int a;
        int v;
        cnt = 0;
        for (int q = -r; q <= r; q++)
        begin
            v = sample_at(sel, k + q, n);
            a = cnt;
            while (a > 0 && w[a-1] > v)
            begin
                w[a] = w[a-1];
                a--;
            end
            w[a] = v;
            cnt++;
        end
        return w[cnt/2];
    endfunction

    function automatic int gauss_mean(int sel, int j, int n, int r, longint wt[RADIUS_CAP+1]);
        longint acc, tot;
        int k;
        acc = 0;
        tot = 0;
        for (int o = -r; o <= r; o++)
        begin
            k = j + o;
            if (k < 0)
                k = 0;
            if (k > n)
                k = n;
            acc += longint'(window_median(sel, k, n, r)) * wt[o < 0 ? -o : o];
            tot += wt[o < 0 ? -o : o];
        end
        if (acc >= 0)
            return int'((acc + tot / 2) / tot);
        return -int'((-acc + tot / 2) / tot);
    endfunction

    function automatic int corrected(int sel, int j, int n, int r, longint wt[RADIUS_CAP+1]);
        int base;
        int raw;
        int diff;
        base = gauss_mean(sel, j, n, r, wt);
        raw  = sample_at(sel, j, n);
        diff = raw - base;
        if (diff < 0)
            diff = -diff;
        return (diff > tol_reg) ? base : raw;
    endfunction

    // advances the shadow state by one row and queues the rows it releases
    task automatic predict_row(int lx, int rx, int ry, bit last);
        longint wt [RADIUS_CAP+1];
        int n, r, kmax, p, j, i, l, rt, s;
        edge_result_t res;
        if (rows_in_track == 0)
            track_radius = (radius_reg > RADIUS_CAP) ? RADIUS_CAP : radius_reg;
        r = track_radius;
        ring_head = (ring_head + 1) % DEPTH;
        n = rows_in_track;
        edge_mem[0][ring_head] = lx;
        edge_mem[1][ring_head] = rx;
        row_mem[ring_head] = ry;
        if (rows_in_track < 65535)
            rows_in_track++;
        for (int o = 0; o <= r; o++)
            wt[o] = longint'(weight_q15(r, o));
        kmax = last ? 4 * r : 0;
        for (int k = 0; k <= kmax; k++)
        begin
            p = n + k;
            j = p - 2 * r;
            i = p - 4 * r;
            if (j >= 0 && j <= n)
            begin
                s = slot(j, n);
                edge_mem[2][s] = corrected(0, j, n, r, wt);
                edge_mem[3][s] = corrected(1, j, n, r, wt);
            end
            if (i >= 0 && i <= n)
            begin
                l  = gauss_mean(2, i, n, r, wt);
                rt = gauss_mean(3, i, n, r, wt);
                res.left_e  = l[15:0];
                res.right_e = rt[15:0];
                res.centre  = 16'((l + rt) >>> 1);
                res.span    = (rt - l < 0) ? 16'd0 : 16'(rt - l);
                res.row     = row_mem[slot(i, n)][15:0];
                res.eot     = last && (i == n);
                smoothed_q.insert(smoothed_q.size(), res);
            end
        end
        if (last)
            rows_in_track = 0;
    endtask

    task automatic stream_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic send_row(logic signed [15:0] lx, logic signed [15:0] rx,
                            logic [15:0] ry, bit last);
        @(negedge clk);
        if (!no_idling && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ry, rx, lx};
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        predict_row(int'(lx), int'(rx), int'(ry), last);
    endtask

    // block idle: all results in and the sequencer given time to finish
    task automatic settle();
        stream_idle();
        wait (smoothed_q.size() == 0);
        repeat (8000) @(negedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_WINDOW_RADIUS)
            radius_reg = int'(val[3:0]);
        else
            tol_reg = int'(val);
    endtask

    // wandering edge pair with occasional spikes and wild values
    task automatic send_track(int len, int y0);
        int cx, wd, lx, rx;
        cx = $urandom_range(0, 40000) - 20000;
        wd = $urandom_range(0, 3000);
        for (int k = 0; k < len; k++)
        begin
            cx += $urandom_range(0, 64) - 32;
            wd += $urandom_range(0, 32) - 16;
            lx = cx - wd / 2;
            rx = cx + wd / 2;
            if ($urandom_range(0, 6) == 0)
                lx += $urandom_range(0, 2000) - 1000;
            if ($urandom_range(0, 6) == 0)
                rx += $urandom_range(0, 2000) - 1000;
            if ($urandom_range(0, 9) == 0)
                lx = $urandom;
            if ($urandom_range(0, 9) == 0)
                rx = $urandom;
            send_row(16'(lx), 16'(rx), 16'(y0 + k), k == len - 1);
        end
    endtask

    task automatic test_extremes();
        send_row(16'sh8000, 16'sh7fff, 16'd0, 1'b0);
        send_row(16'sh7fff, 16'sh8000, 16'hffff, 1'b0);
        send_row(16'sh0100, 16'sh0200, 16'd2, 1'b0);
        send_row(16'sh0104, 16'sh01f0, 16'd3, 1'b0);
        send_row(16'sh0f00, 16'sh0208, 16'd4, 1'b0);
        send_row(16'sh0102, 16'sh8000, 16'd5, 1'b0);
        send_row(16'sh0100, 16'sh0200, 16'd6, 1'b0);
        send_row(16'shffff, 16'sh0000, 16'd7, 1'b0);
        send_row(16'sh0000, 16'shffff, 16'd8, 1'b0);
        send_row(16'sh0101, 16'sh0203, 16'd9, 1'b1);
        settle();
    endtask

    task automatic test_radius_zero();
        write_reg(REG_WINDOW_RADIUS, 12'hff0);
        write_reg(REG_OUTLIER_TOL, 12'd0);
        send_row(16'sh8000, 16'sh7fff, 16'h5555, 1'b1);
        send_row(16'sh7fff, 16'sh8000, 16'haaaa, 1'b0);
        send_row(16'sh0003, 16'sh0001, 16'd1, 1'b1);
        settle();
    endtask

    task automatic test_radius_saturation();
        write_reg(REG_WINDOW_RADIUS, 12'd15);
        write_reg(REG_OUTLIER_TOL, 12'd4095);
        send_track(6, 100);
        settle();
    endtask

    // radius change waits for the next track, tolerance applies at once
    task automatic test_mid_track_writes();
        write_reg(REG_WINDOW_RADIUS, 12'd2);
        write_reg(REG_OUTLIER_TOL, 12'd40);
        send_track(12, 200);
        settle();
        send_row(16'sh0400, 16'sh0800, 16'd300, 1'b0);
        send_row(16'sh0400, 16'sh0800, 16'd301, 1'b0);
        settle();
        write_reg(REG_OUTLIER_TOL, 12'd0);
        write_reg(REG_WINDOW_RADIUS, 12'd1);
        send_row(16'sh0500, 16'sh0700, 16'd302, 1'b0);
        send_row(16'sh0400, 16'sh0800, 16'd303, 1'b1);
        settle();
        send_track(5, 400);
        settle();
    endtask

    // long track at radius one wraps the row buffers
    task automatic test_ring_wrap();
        send_track(70, 1000);
        settle();
    endtask

    task automatic test_random_tracks();
        int sent;
        int len;
        sent = 0;
        while (sent < 40)
        begin
            if ($urandom_range(0, 7) == 0)
                write_reg(REG_WINDOW_RADIUS, 12'($urandom_range(6, 15)));
            else
                write_reg(REG_WINDOW_RADIUS, 12'($urandom_range(0, 3)));
            case ($urandom_range(0, 4))
                0: write_reg(REG_OUTLIER_TOL, 12'd0);
                1: write_reg(REG_OUTLIER_TOL, 12'd4095);
                default: write_reg(REG_OUTLIER_TOL, 12'($urandom_range(8, 600)));
            endcase
            len = (radius_reg > 3) ? $urandom_range(1, 6) : $urandom_range(1, 24);
            no_idling = (sent > 28);
            send_track(len, $urandom_range(0, 65535));
            sent += len;
            settle();
        end
    endtask

    // receiver stalls in bursts
    initial
    begin
        int hold;
        m_tready = 1'b0;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                hold--;
                m_tready <= 1'b0;
            end
            else if (!no_idling && $urandom_range(0, 4) == 0)
            begin
                hold = $urandom_range(1, 9) - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        edge_result_t exp_r;
        logic [OUT_TDATA_W-1:0] exp_d;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (smoothed_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: tdata %h tlast %b", m_tdata, m_tlast);
            end
            else
            begin
                exp_r = smoothed_q.pop_front();
                exp_d = {exp_r.row, exp_r.span, exp_r.centre, exp_r.right_e, exp_r.left_e};
                if (m_tdata !== exp_d || m_tlast !== exp_r.eot)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected tdata %h tlast %b, got %h %b",
                                 exp_d, exp_r.eot, m_tdata, m_tlast);
                end
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_WINDOW_RADIUS;
        cfg_wdata = '0;
        mismatches    = 0;
        idle_cycles   = 0;
        no_idling     = 1'b0;
        rows_in_track = 0;
        ring_head     = 0;
        track_radius  = 3;
        radius_reg    = 3;
        tol_reg       = 160;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        test_extremes();
        test_radius_zero();
        test_radius_saturation();
        test_mid_track_writes();
        test_ring_wrap();
        test_random_tracks();

        stream_idle();
        wait (smoothed_q.size() == 0);
        repeat (200) @(negedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
